FILE: sv/lru_page_buffer_pool_defines.svh
// Assertion macros for the page buffer pool.
// Used by the top level only.
`ifndef LRU_PAGE_BUFFER_POOL_DEFINES_SVH
`define LRU_PAGE_BUFFER_POOL_DEFINES_SVH
`define LPBP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpbp check failed");
`define LPBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpbp check failed");
`endif

FILE: sv/lpbp_pkg.sv
// Package for the page buffer pool: sizes, codes and entry layout.
// No dependencies.
package lpbp_pkg;
   localparam int NumFrames = 64;
   localparam int PinBits   = 8;
   localparam int FrameW    = $clog2(NumFrames);
   localparam int CntW      = $clog2(NumFrames + 1);

   typedef enum logic [1:0] {
      ACT_READ = 2'd0, ACT_UNPIN = 2'd1, ACT_FREE = 2'd2, ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0, ST_MISS = 3'd1, ST_UNPIN = 3'd2, ST_FREED = 3'd3,
      ST_NOTBUF = 3'd4, ST_PINNED = 3'd5
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [PinBits-1:0] pin;
      logic [15:0]       tbl;
      logic [31:0]       pg;
   } entry_type;

   typedef struct packed {
      logic [FrameW-1:0] newer;
      logic [FrameW-1:0] older;
   } link_type;

   localparam int EntryW = $bits(entry_type);
   localparam int LinkW  = $bits(link_type);
endpackage

FILE: sv/lpbp_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module lpbp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/lru_page_buffer_pool.sv
// Channel | ports                             | direction
// req     | req_valid/req_stall, five fields  | in
// rsp     | rsp_valid/rsp_stall, seven fields | out
// One item at a time. A read or free scans all NumFrames entries, one per cycle, then
// reads the entry; a read, or a free that frees it, writes it and relinks the recency
// list in up to seven link steps. An unpin reads and writes the entry without relinking.
// After reset a clearing pass writes entries and links; req_stall is high during it.
// A stalled result holds the last step and so stalls the input.
// Depends on lpbp_pkg, lpbp_ram and lru_page_buffer_pool_defines.svh.
`include "lru_page_buffer_pool_defines.svh"
module lru_page_buffer_pool (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_table_id,
   input  logic [31:0] req_page_number,
   input  logic [5:0]  req_frame,
   input  logic        req_dirty,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_frame_index,
   output logic        rsp_writeback_valid,
   output logic [15:0] rsp_writeback_table,
   output logic [31:0] rsp_writeback_page,
   output logic        rsp_load_valid,
   output logic [7:0]  rsp_pin_after
);
   localparam int FW = lpbp_pkg::FrameW;
   localparam int PB = lpbp_pkg::PinBits;
   localparam logic [PB-1:0] PinMax = '1;

   typedef enum logic [14:0] {
      S_CLEAR = 15'd1, S_IDLE = 15'd2, S_SCAN = 15'd4, S_SCANW = 15'd8,
      S_DEC = 15'd16, S_ERD = 15'd32, S_EWR = 15'd64, S_LRD = 15'd128,
      S_L1 = 15'd256, S_L2 = 15'd512, S_L3 = 15'd1024, S_L4 = 15'd2048,
      S_L5 = 15'd4096, S_L6 = 15'd8192, S_OUT = 15'd16384
   } state_type;

   state_type state_ff, state_in;
   logic [lpbp_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [FW-1:0] tail_ff, tail_in;
   logic [1:0]  act_ff, act_in;
   logic [15:0] tbl_ff, tbl_in;
   logic [31:0] pg_ff, pg_in;
   logic [5:0]  fr_ff, fr_in;
   logic        dty_ff, dty_in;
   logic        hit_ff, hit_in;
   logic [FW-1:0] c_ff, c_in;
   lpbp_pkg::link_type lc_ff, lc_in;
   logic [FW-1:0] front_ff, front_in;
   logic        fwd_v_ff, fwd_v_in;
   lpbp_pkg::link_type fwd_d_ff, fwd_d_in;
   logic [2:0]  r_st_ff, r_st_in;
   logic [5:0]  r_fi_ff, r_fi_in;
   logic        r_wbv_ff, r_wbv_in;
   logic [15:0] r_wbt_ff, r_wbt_in;
   logic [31:0] r_wbp_ff, r_wbp_in;
   logic        r_ldv_ff, r_ldv_in;
   logic [7:0]  r_pin_ff, r_pin_in;
   logic [2:0]  o_st_ff, o_st_in;
   logic [5:0]  o_fi_ff, o_fi_in;
   logic        o_wbv_ff, o_wbv_in;
   logic [15:0] o_wbt_ff, o_wbt_in;
   logic [31:0] o_wbp_ff, o_wbp_in;
   logic        o_ldv_ff, o_ldv_in;
   logic [7:0]  o_pin_ff, o_pin_in;
   logic        o_v_ff, o_v_in;

   logic e_we; logic [FW-1:0] e_wa, e_ra;
   lpbp_pkg::entry_type e_wd, e_rd;
   logic l_we; logic [FW-1:0] l_wa, l_ra;
   lpbp_pkg::link_type l_wd, l_rd, lrd;

   lpbp_ram #(.Width(lpbp_pkg::EntryW), .Depth(lpbp_pkg::NumFrames)) u_ent (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   lpbp_ram #(.Width(lpbp_pkg::LinkW), .Depth(lpbp_pkg::NumFrames)) u_lnk (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_rd));

   logic [FW-1:0] scan_idx, prev_idx;
   logic          match, last_scan;
   assign scan_idx  = cnt_ff[FW-1:0];
   assign prev_idx  = FW'(cnt_ff - 1'b1);
   assign match     = e_rd.valid && e_rd.tbl == tbl_ff && e_rd.pg == pg_ff;
   assign last_scan = cnt_ff == lpbp_pkg::CntW'(lpbp_pkg::NumFrames);
   // link read issued in the cycle of a write to the same entry
   assign lrd       = fwd_v_ff ? fwd_d_ff : l_rd;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = o_v_ff;
   assign rsp_status = o_st_ff;
   assign rsp_frame_index = o_fi_ff;
   assign rsp_writeback_valid = o_wbv_ff;
   assign rsp_writeback_table = o_wbt_ff;
   assign rsp_writeback_page = o_wbp_ff;
   assign rsp_load_valid = o_ldv_ff;
   assign rsp_pin_after = o_pin_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; tail_in = tail_ff;
      act_in = act_ff; tbl_in = tbl_ff; pg_in = pg_ff; fr_in = fr_ff; dty_in = dty_ff;
      hit_in = hit_ff; c_in = c_ff; lc_in = lc_ff; front_in = front_ff;
      r_st_in = r_st_ff; r_fi_in = r_fi_ff; r_wbv_in = r_wbv_ff; r_wbt_in = r_wbt_ff;
      r_wbp_in = r_wbp_ff; r_ldv_in = r_ldv_ff; r_pin_in = r_pin_ff;
      o_st_in = o_st_ff; o_fi_in = o_fi_ff; o_wbv_in = o_wbv_ff; o_wbt_in = o_wbt_ff;
      o_wbp_in = o_wbp_ff; o_ldv_in = o_ldv_ff; o_pin_in = o_pin_ff; o_v_in = o_v_ff;
      e_we = 1'b0; e_wa = c_ff; e_wd = e_rd; e_ra = c_ff;
      l_we = 1'b0; l_wa = c_ff; l_wd = lrd; l_ra = c_ff;
      if (o_v_ff && !rsp_stall) o_v_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            e_we = 1'b1; e_wa = scan_idx; e_wd = '0;
            l_we = 1'b1; l_wa = scan_idx;
            l_wd.newer = FW'(scan_idx + 1'b1);
            l_wd.older = FW'(scan_idx - 1'b1);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lpbp_pkg::CntW'(lpbp_pkg::NumFrames - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; tbl_in = req_table_id; pg_in = req_page_number;
               fr_in = req_frame; dty_in = req_dirty; hit_in = 1'b0; cnt_in = '0;
               unique case (lpbp_pkg::action_type'(req_action))
                  lpbp_pkg::ACT_READ, lpbp_pkg::ACT_FREE: state_in = S_SCAN;
                  lpbp_pkg::ACT_UNPIN: state_in = S_DEC;
                  default: begin
                     r_st_in = lpbp_pkg::ST_NOTBUF; r_fi_in = '0; r_wbv_in = 1'b0;
                     r_wbt_in = '0; r_wbp_in = '0; r_ldv_in = 1'b0; r_pin_in = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            e_ra = scan_idx; cnt_in = cnt_ff + 1'b1; state_in = S_SCANW;
         end
         S_SCANW: begin
            e_ra = scan_idx;
            if (cnt_ff != '0 && match && !hit_ff) begin
               hit_in = 1'b1; c_in = prev_idx;
            end
            if (last_scan) begin
               state_in = S_ERD;
               if (!(hit_in)) c_in = tail_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DEC: begin
            // unpin: read entry, then modify in S_EWR
            c_in = fr_ff[FW-1:0]; e_ra = fr_ff[FW-1:0]; state_in = S_EWR;
            if ({1'b0, fr_ff} >= 7'(lpbp_pkg::NumFrames)) begin
               r_st_in = lpbp_pkg::ST_UNPIN; r_fi_in = fr_ff; r_wbv_in = 1'b0;
               r_wbt_in = '0; r_wbp_in = '0; r_ldv_in = 1'b0; r_pin_in = '0;
               state_in = S_OUT;
            end
         end
         S_ERD: begin
            e_ra = c_ff; state_in = S_EWR;
         end
         S_EWR: begin
            e_wa = c_ff; e_wd = e_rd;
            r_wbv_in = 1'b0; r_wbt_in = '0; r_wbp_in = '0; r_ldv_in = 1'b0;
            r_fi_in = 6'(c_ff); state_in = S_OUT;
            if (act_ff == lpbp_pkg::ACT_UNPIN) begin
               e_we = 1'b1;
               if (e_rd.pin != '0) e_wd.pin = e_rd.pin - 1'b1;
               if (dty_ff) e_wd.dirty = 1'b1;
               r_st_in = lpbp_pkg::ST_UNPIN; r_pin_in = 8'(e_wd.pin);
            end else if (act_ff == lpbp_pkg::ACT_READ) begin
               e_we = 1'b1;
               e_wd.pin = (e_rd.pin == PinMax) ? PinMax : e_rd.pin + 1'b1;
               r_pin_in = 8'(e_wd.pin);
               if (hit_ff) r_st_in = lpbp_pkg::ST_HIT;
               else begin
                  r_st_in = lpbp_pkg::ST_MISS; r_ldv_in = 1'b1;
                  if (e_rd.valid && e_rd.dirty) begin
                     r_wbv_in = 1'b1; r_wbt_in = e_rd.tbl; r_wbp_in = e_rd.pg;
                  end
                  e_wd.valid = 1'b1; e_wd.dirty = 1'b0;
                  e_wd.tbl = tbl_ff; e_wd.pg = pg_ff;
               end
               state_in = S_LRD;
            end else begin
               if (!hit_ff) begin
                  r_st_in = lpbp_pkg::ST_NOTBUF; r_fi_in = '0; r_pin_in = '0;
               end else if (e_rd.pin != '0) begin
                  r_st_in = lpbp_pkg::ST_PINNED; r_pin_in = 8'(e_rd.pin);
               end else begin
                  e_we = 1'b1; e_wd = '0;
                  r_st_in = lpbp_pkg::ST_FREED; r_pin_in = '0;
                  state_in = S_LRD;
               end
            end
         end
         S_LRD: begin
            l_ra = c_ff; state_in = S_L1;
         end
         S_L1: begin
            // links of c; if c is the tail, a read only advances the tail and a free keeps it
            lc_in = lrd;
            if (c_ff == tail_ff) begin
               tail_in = (act_ff == lpbp_pkg::ACT_FREE) ? c_ff : lrd.newer;
               state_in = S_OUT;
            end else begin
               l_ra = lrd.older; state_in = S_L2;
            end
         end
         S_L2: begin
            // newer(older(c)) = newer(c)
            l_we = 1'b1; l_wa = lc_ff.older;
            l_wd.newer = lc_ff.newer; l_wd.older = lrd.older;
            l_ra = lc_ff.newer; state_in = S_L3;
         end
         S_L3: begin
            // older(newer(c)) = older(c)
            l_we = 1'b1; l_wa = lc_ff.newer;
            l_wd.newer = lrd.newer; l_wd.older = lc_ff.older;
            l_ra = tail_ff; state_in = S_L4;
         end
         S_L4: begin
            // front = older(tail); older(tail) = c
            l_we = 1'b1; l_wa = tail_ff;
            l_wd.newer = lrd.newer; l_wd.older = c_ff;
            front_in = lrd.older;
            l_ra = lrd.older; state_in = S_L5;
         end
         S_L5: begin
            l_we = 1'b1; l_wa = front_ff;
            l_wd.newer = c_ff; l_wd.older = lrd.older;
            state_in = S_L6;
         end
         S_L6: begin
            l_we = 1'b1; l_wa = c_ff;
            l_wd.newer = tail_ff; l_wd.older = front_ff;
            if (act_ff == lpbp_pkg::ACT_FREE) tail_in = c_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!o_v_ff || !rsp_stall) begin
               o_v_in = 1'b1;
               o_st_in = r_st_ff; o_fi_in = r_fi_ff; o_wbv_in = r_wbv_ff;
               o_wbt_in = r_wbt_ff; o_wbp_in = r_wbp_ff; o_ldv_in = r_ldv_ff;
               o_pin_in = r_pin_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      fwd_v_in = l_we && (l_wa == l_ra);
      fwd_d_in = l_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0; tail_ff <= '0; o_v_ff <= 1'b0;
         hit_ff <= 1'b0; act_ff <= '0; fwd_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; tail_ff <= tail_in; o_v_ff <= o_v_in;
         hit_ff <= hit_in; act_ff <= act_in; fwd_v_ff <= fwd_v_in;
      end
      tbl_ff <= tbl_in; pg_ff <= pg_in; fr_ff <= fr_in; dty_ff <= dty_in;
      c_ff <= c_in; lc_ff <= lc_in; front_ff <= front_in; fwd_d_ff <= fwd_d_in;
      r_st_ff <= r_st_in; r_fi_ff <= r_fi_in; r_wbv_ff <= r_wbv_in;
      r_wbt_ff <= r_wbt_in; r_wbp_ff <= r_wbp_in; r_ldv_ff <= r_ldv_in;
      r_pin_ff <= r_pin_in;
      o_st_ff <= o_st_in; o_fi_ff <= o_fi_in; o_wbv_ff <= o_wbv_in;
      o_wbt_ff <= o_wbt_in; o_wbp_ff <= o_wbp_in; o_ldv_ff <= o_ldv_in;
      o_pin_ff <= o_pin_in;
   end

   `LPBP_ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall)
   `LPBP_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall,
      state_ff != S_IDLE)
   `LPBP_ASSERT_IMPL(a_load_miss, clock, reset, rsp_valid && rsp_load_valid,
      rsp_status == lpbp_pkg::ST_MISS)
   `LPBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_frame_index))
endmodule
